/* rtl/tws_pkg.sv */
// Package for the three-wire serial master: request/result structs, request codes
// and segment numbering constants. No dependencies.
package tws_pkg;

  localparam int unsigned SEG_W = 6;
  localparam int unsigned TICK_W = 16;

  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_WRITE  = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam logic [SEG_W-1:0] SEG_FIRST    = 6'd0;
  localparam logic [SEG_W-1:0] SEG_CLK_LOW  = 6'd1;
  localparam logic [SEG_W-1:0] SEG_CMD_END  = 6'd16;
  localparam logic [SEG_W-1:0] SEG_RELEASE  = 6'd17;
  localparam logic [SEG_W-1:0] SEG_RX_LAST  = 6'd31;
  localparam logic [SEG_W-1:0] SEG_RX_END   = 6'd32;
  localparam logic [SEG_W-1:0] SEG_REDRIVE  = 6'd33;
  localparam logic [SEG_W-1:0] SEG_LAST     = 6'd34;

  localparam logic [TICK_W-1:0] SEG_TICKS_RESET = 16'd10;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] cmd_byte;
    logic [7:0] write_byte;
    logic       data_pin_in;
  } in_item_t;

  typedef struct packed {
    logic       chip_enable;
    logic       serial_clock;
    logic       data_pin_out;
    logic       data_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_result;
    logic       rejected;
  } out_item_t;

  typedef struct packed {
    logic              en;
    in_item_t          item;
    logic [TICK_W-1:0] seg_ticks;
  } step_req_t;

endpackage

/* rtl/three_wire_serial_master.sv */
// Top level of the three-wire serial master: input register, step core, result
// register and segment length register. Depends on tws_pkg and tws_core.
//
//   channel | direction | handshake         | payload
//   in_     | input     | in_valid/in_stall | tws_pkg::in_item_t (one tick)
//   out_    | output    | out_valid/out_stall | tws_pkg::out_item_t (pin levels)
//   cfg_    | input     | cfg_valid/cfg_ready | segment_ticks, 16 bits
//
// One request per cycle unless out_ stalls; each request shows on out_ after both registers.
// The step core updates on the cycle a request moves from the input register
// into the result register. A stalled output holds both registers; in_stall rises
// only when both are full. Synchronous reset; segment_ticks resets to 10.
module three_wire_serial_master (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tws_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output tws_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data
);
  import tws_pkg::*;

  logic              in_valid_r;
  in_item_t          in_item_r;
  logic              out_valid_r;
  out_item_t         out_item_r;
  logic [TICK_W-1:0] seg_ticks_r;
  logic              advance;
  logic              in_take;
  step_req_t         step;
  out_item_t         step_res;

  assign advance   = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !advance;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign step = {advance, in_item_r, seg_ticks_r};

  tws_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .result (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      seg_ticks_r <= SEG_TICKS_RESET;
    end else begin
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        seg_ticks_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_item;
    end
    if (advance) begin
      out_item_r <= step_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.done_res |-> !out_item_r.busy_res && !out_item_r.chip_enable)
    else $error("transaction done while still busy or chip enabled");

  a_release_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_item_r.data_drive |-> out_item_r.busy_res && out_item_r.chip_enable)
    else $error("data line released outside a read transaction");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> in_valid_r && $stable(in_item_r))
    else $error("input register changed while stalled");

endmodule

/* rtl/tws_core.sv */
// Transaction state and per-tick step logic of the three-wire serial master.
// Depends on tws_pkg.
module tws_core (
  input  logic               clk,
  input  logic               rst_n,
  input  tws_pkg::step_req_t step,
  output tws_pkg::out_item_t result
);
  import tws_pkg::*;

  logic              active_r, active_nxt;
  logic              is_read_r, is_read_nxt;
  logic [SEG_W-1:0]  seg_r, seg_nxt;
  logic [TICK_W-1:0] tick_r, tick_nxt;
  logic [15:0]       send_r, send_nxt;
  logic [7:0]        recv_r, recv_nxt;
  logic              ce_r, ce_nxt;
  logic              clk_pin_r, clk_pin_nxt;
  logic              data_r, data_nxt;
  logic              drive_r, drive_nxt;
  logic [7:0]        last_r, last_nxt;

  logic [TICK_W-1:0] len;
  logic [TICK_W:0]   tick_inc;
  logic [SEG_W-1:0]  s;
  logic              is_req;
  logic              shown_ce, shown_clk, shown_data, shown_drive;
  logic              done, rej;

  assign len = (step.seg_ticks == '0) ? TICK_W'(1) : step.seg_ticks;
  assign is_req = (step.item.req_type == REQ_WRITE) || (step.item.req_type == REQ_READ);

  always_comb begin
    active_nxt  = active_r;
    is_read_nxt = is_read_r;
    seg_nxt     = seg_r;
    tick_nxt    = tick_r;
    send_nxt    = send_r;
    recv_nxt    = recv_r;
    ce_nxt      = ce_r;
    clk_pin_nxt = clk_pin_r;
    data_nxt    = data_r;
    drive_nxt   = drive_r;
    last_nxt    = last_r;
    done        = 1'b0;
    rej         = 1'b0;
    tick_inc    = '0;
    s           = '0;

    if (is_req) begin
      if (active_r) begin
        rej = 1'b1;
      end else begin
        active_nxt  = 1'b1;
        is_read_nxt = (step.item.req_type == REQ_READ);
        seg_nxt     = SEG_FIRST;
        tick_nxt    = '0;
        send_nxt    = {step.item.write_byte, step.item.cmd_byte};
        recv_nxt    = '0;
        if (step.item.req_type == REQ_WRITE) begin
          drive_nxt = 1'b1;
        end
        ce_nxt = 1'b1;
      end
    end

    shown_ce    = ce_nxt;
    shown_clk   = clk_pin_nxt;
    shown_data  = data_nxt;
    shown_drive = drive_nxt;

    if (active_nxt) begin
      tick_inc = {1'b0, tick_nxt} + (TICK_W+1)'(1);
      if (tick_inc >= {1'b0, len}) begin
        tick_nxt = '0;
        if (is_read_nxt && seg_nxt >= SEG_RELEASE && seg_nxt <= SEG_RX_LAST && seg_nxt[0]) begin
          recv_nxt = {step.item.data_pin_in, recv_nxt[7:1]};
        end
        s = seg_nxt + SEG_W'(1);
        if (seg_nxt == SEG_LAST) begin
          active_nxt = 1'b0;
          done       = 1'b1;
          seg_nxt    = SEG_FIRST;
          if (is_read_nxt) begin
            last_nxt = recv_nxt;
          end
        end else begin
          seg_nxt = s;
          if (s == SEG_LAST) begin
            ce_nxt = 1'b0;
          end else if (!is_read_nxt) begin
            if (s > SEG_CLK_LOW && !s[0]) begin
              data_nxt    = send_nxt[0];
              send_nxt    = {1'b0, send_nxt[15:1]};
              clk_pin_nxt = 1'b1;
            end else begin
              clk_pin_nxt = 1'b0;
            end
          end else if (s <= SEG_CMD_END) begin
            if (s[0]) begin
              clk_pin_nxt = 1'b0;
            end else begin
              data_nxt    = send_nxt[0];
              send_nxt    = {1'b0, send_nxt[15:1]};
              clk_pin_nxt = 1'b1;
            end
          end else if (s <= SEG_RX_END) begin
            if (s == SEG_RELEASE) begin
              drive_nxt = 1'b0;
            end
            clk_pin_nxt = !s[0];
          end else begin
            drive_nxt   = 1'b1;
            clk_pin_nxt = 1'b0;
          end
        end
      end else begin
        tick_nxt = tick_inc[TICK_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 1'b0;
      is_read_r <= 1'b0;
      seg_r     <= '0;
      tick_r    <= '0;
      send_r    <= '0;
      recv_r    <= '0;
      ce_r      <= 1'b0;
      clk_pin_r <= 1'b0;
      data_r    <= 1'b0;
      drive_r   <= 1'b1;
      last_r    <= '0;
    end else if (step.en) begin
      active_r  <= active_nxt;
      is_read_r <= is_read_nxt;
      seg_r     <= seg_nxt;
      tick_r    <= tick_nxt;
      send_r    <= send_nxt;
      recv_r    <= recv_nxt;
      ce_r      <= ce_nxt;
      clk_pin_r <= clk_pin_nxt;
      data_r    <= data_nxt;
      drive_r   <= drive_nxt;
      last_r    <= last_nxt;
    end
  end

  always_comb begin
    result.chip_enable  = shown_ce;
    result.serial_clock = shown_clk;
    result.data_pin_out = shown_data;
    result.data_drive   = shown_drive;
    result.busy_res     = active_nxt;
    result.done_res     = done;
    result.read_result  = last_nxt;
    result.rejected     = rej;
  end

endmodule

/* verif/three_wire_serial_master_tb.sv */
// Testbench for three_wire_serial_master: drives tick requests and segment lengths,
// predicts the pin levels of every tick and checks each result in order.
// Depends on tws_pkg and the three_wire_serial_master RTL.
module three_wire_serial_master_tb;
  import tws_pkg::*;

  localparam int CLK_HALF = 6;
  localparam int LIMIT_CYCLES = 400000;

  class pin_scoreboard;
    logic [15:0] seg_ticks;
    bit          active;
    bit          is_read;
    logic [5:0]  seg_idx;
    logic [15:0] tick_cnt;
    logic [15:0] send_sr;
    logic [7:0]  recv_sr;
    logic [7:0]  last_rd;
    bit          ce, sclk, dout, drive;
    out_item_t   expected_pins[$];
    int          mismatches, ticks, writes, reads, rejects, dones;

    function new();
      seg_ticks = SEG_TICKS_RESET;
      active = 0;
      is_read = 0;
      seg_idx = SEG_FIRST;
      tick_cnt = '0;
      send_sr = '0;
      recv_sr = '0;
      last_rd = '0;
      ce = 0;
      sclk = 0;
      dout = 0;
      drive = 1;
    endfunction

    function void put_next_bit();
      dout = send_sr[0];
      send_sr = send_sr >> 1;
      sclk = 1;
    endfunction

    function void enter_segment(logic [5:0] s);
      if (s == SEG_FIRST) begin
        ce = 1;
      end else if (s == SEG_LAST) begin
        ce = 0;
      end else if (!is_read) begin
        if (s > SEG_CLK_LOW && !s[0]) put_next_bit();
        else sclk = 0;
      end else if (s <= SEG_CMD_END) begin
        if (s[0]) sclk = 0;
        else put_next_bit();
      end else if (s <= SEG_RX_END) begin
        if (s == SEG_RELEASE) drive = 0;
        sclk = !s[0];
      end else begin
        drive = 1;
        sclk = 0;
      end
    endfunction

    function void note_request(in_item_t req);
      out_item_t   pins;
      bit          rej, done;
      logic [16:0] len;
      logic [5:0]  s;
      rej = 0;
      done = 0;
      len = (seg_ticks == 0) ? 17'd1 : {1'b0, seg_ticks};
      ticks++;
      if (req.req_type == REQ_WRITE || req.req_type == REQ_READ) begin
        if (active) begin
          rej = 1;
          rejects++;
        end else begin
          active = 1;
          is_read = (req.req_type == REQ_READ);
          if (is_read) reads++;
          else writes++;
          seg_idx = SEG_FIRST;
          tick_cnt = '0;
          send_sr = {req.write_byte, req.cmd_byte};
          recv_sr = '0;
          if (!is_read) drive = 1;
          enter_segment(SEG_FIRST);
        end
      end
      pins.chip_enable = ce;
      pins.serial_clock = sclk;
      pins.data_pin_out = dout;
      pins.data_drive = drive;
      if (active) begin
        if ({1'b0, tick_cnt} + 17'd1 >= len) begin
          s = seg_idx;
          tick_cnt = '0;
          if (is_read && s >= SEG_RELEASE && s <= SEG_RX_LAST && s[0])
            recv_sr = {req.data_pin_in, recv_sr[7:1]};
          if (s == SEG_LAST) begin
            active = 0;
            done = 1;
            dones++;
            seg_idx = SEG_FIRST;
            if (is_read) last_rd = recv_sr;
          end else begin
            seg_idx = s + 6'd1;
            enter_segment(seg_idx);
          end
        end else begin
          tick_cnt = tick_cnt + 16'd1;
        end
      end
      pins.busy_res = active;
      pins.done_res = done;
      pins.read_result = last_rd;
      pins.rejected = rej;
      expected_pins.push_back(pins);
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatches++;
    endtask

    task compare_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) report($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    task check_pins(out_item_t got);
      out_item_t want;
      if (expected_pins.size() == 0) begin
        report("result with no request outstanding");
      end else begin
        want = expected_pins.pop_front();
        compare_field("chip_enable", 8'(got.chip_enable), 8'(want.chip_enable));
        compare_field("serial_clock", 8'(got.serial_clock), 8'(want.serial_clock));
        compare_field("data_pin_out", 8'(got.data_pin_out), 8'(want.data_pin_out));
        compare_field("data_drive", 8'(got.data_drive), 8'(want.data_drive));
        compare_field("busy_res", 8'(got.busy_res), 8'(want.busy_res));
        compare_field("done_res", 8'(got.done_res), 8'(want.done_res));
        compare_field("read_result", got.read_result, want.read_result);
        compare_field("rejected", 8'(got.rejected), 8'(want.rejected));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  pin_scoreboard board = new();
  bit gaps_on = 1;
  bit stalls_on = 1;
  bit long_hold_req = 0;
  int hold_cycles = 0;

  three_wire_serial_master i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  function automatic int pick_len();
    if ($urandom_range(99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic in_item_t make_request(logic [1:0] code, logic [7:0] cmd,
                                            logic [7:0] wb, logic din);
    in_item_t req;
    req.req_type = code;
    req.cmd_byte = cmd;
    req.write_byte = wb;
    req.data_pin_in = din;
    return req;
  endfunction

  // Start a transaction soon after the previous one ends; rarely poke a busy master.
  function automatic in_item_t random_request();
    int       r;
    logic [1:0] code;
    r = $urandom_range(99);
    code = REQ_TICK;
    if (!board.active) begin
      if (r < 22) code = REQ_WRITE;
      else if (r < 45) code = REQ_READ;
      else if (r < 50) code = REQ_UNUSED;
    end else begin
      if (r < 2) code = REQ_WRITE;
      else if (r < 4) code = REQ_READ;
      else if (r < 7) code = REQ_UNUSED;
    end
    return make_request(code, 8'($urandom_range(255)), 8'($urandom_range(255)),
                        1'($urandom_range(1)));
  endfunction

  task automatic send_request(input in_item_t req);
    int gap;
    gap = (!gaps_on || $urandom_range(99) < 60) ? 0 : pick_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= req;
    do @(posedge clk); while (!(in_valid && !in_stall));
    board.note_request(req);
  endtask

  task automatic write_segment_ticks(input logic [15:0] value);
    in_valid <= 1'b0;
    while (board.expected_pins.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    board.seg_ticks = value;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) board.check_pins(out_item);
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (long_hold_req) begin
          stall_left = 300;
          hold_cycles = 300;
          long_hold_req = 0;
        end else if (stalls_on && $urandom_range(99) < 20) begin
          stall_left = pick_len();
        end
      end
    end
  end

  initial begin
    #(LIMIT_CYCLES * 2 * CLK_HALF);
    $display("three_wire_serial_master test failed");
    $finish;
  end

  initial begin
    logic [15:0] phase_ticks[6];
    int          phase_items[6];
    logic [1:0]  code;
    int          i, p;
    phase_ticks = '{16'd1, 16'd65535, 16'd3, 16'd2, 16'd1, 16'd4};
    phase_items = '{450, 40, 350, 300, 200, 150};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset segment length, then zero length taken mid-transaction
    send_request(make_request(REQ_WRITE, 8'h00, 8'hFF, 1'b0));
    for (i = 0; i < 19; i++) send_request(make_request(REQ_TICK, 8'hFF, 8'h00, i[0]));
    write_segment_ticks(16'd0);
    while (board.active) send_request(make_request(REQ_TICK, 8'h00, 8'h00, 1'b1));

    // read with busy requests, a request on the done tick and a back-to-back write
    send_request(make_request(REQ_READ, 8'hFF, 8'h00, 1'b1));
    for (i = 1; i < 35; i++) begin
      code = (i == 5) ? REQ_WRITE : (i == 9) ? REQ_UNUSED : (i == 34) ? REQ_READ : REQ_TICK;
      send_request(make_request(code, 8'($urandom_range(255)), 8'($urandom_range(255)),
                                i[0] ^ i[2]));
    end
    send_request(make_request(REQ_WRITE, 8'hFF, 8'h00, 1'b0));
    for (i = 1; i < 35; i++) send_request(make_request(REQ_TICK, 8'h00, 8'hFF, 1'b1));

    for (p = 0; p < 6; p++) begin
      write_segment_ticks(phase_ticks[p]);
      gaps_on = (p != 3 && p != 4);
      stalls_on = (p != 3 && p != 4);
      if (p == 3) long_hold_req = 1;
      for (i = 0; i < phase_items[p]; i++) send_request(random_request());
    end

    in_valid <= 1'b0;
    while (board.expected_pins.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("ran %0d ticks: %0d writes, %0d reads, %0d done, %0d rejected requests",
             board.ticks, board.writes, board.reads, board.dones, board.rejects);
    $display("segment lengths 0 to 4, 10 and 65535; output held off for %0d cycles",
             hold_cycles);
    if (board.mismatches == 0) begin
      $display("three_wire_serial_master test passed");
    end else begin
      $display("three_wire_serial_master test failed");
    end
    $finish;
  end

endmodule

/* three_wire_serial_master.f */
rtl/tws_pkg.sv
rtl/tws_core.sv
rtl/three_wire_serial_master.sv
verif/three_wire_serial_master_tb.sv
